>>> design/flash_bootloader_command_unit_assert.svh
// Assertion helpers shared by the command unit modules.
`ifndef FLASH_BOOTLOADER_COMMAND_UNIT_ASSERT_SVH
`define FLASH_BOOTLOADER_COMMAND_UNIT_ASSERT_SVH

// Check a property on every rising edge outside of reset.
`define FBCU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FBCU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/fbcu_pkg.sv
package fbcu_pkg;

  // Flash page size in bytes
  localparam int PAGE_BYTES = 64;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Page mask applied to the low address byte, and the low byte of the page size
  localparam logic [7:0] PAGE_MASK    = 8'(~(PAGE_BYTES - 1));
  localparam logic [7:0] PAGE_BYTE_LO = 8'(PAGE_BYTES % 256);

  // Reset vector patch words
  localparam logic [15:0] JMP_NEAR_BASE  = 16'hC000;
  localparam logic [15:0] JMP_FAR_OPCODE = 16'h940C;
  localparam logic [15:0] FAR_LIMIT      = 16'd8192;

  localparam logic [7:0] CODE_MASK = 8'h3F;

  // Request codes
  localparam logic [7:0] REQ_INFO = 8'd0;
  localparam logic [7:0] REQ_PAGE = 8'd1;
  localparam logic [7:0] REQ_DATA = 8'd3;
  localparam logic [5:0] MREQ_ERASE = 6'd2;
  localparam logic [5:0] MREQ_EXIT  = 6'd4;

  // Reset values of the configuration registers
  localparam logic [15:0] BOOT_ADDRESS_RST    = 16'd6144;
  localparam logic [7:0]  WRITE_SLEEP_MS_RST  = 8'd5;
  localparam logic [7:0]  SIGNATURE_ONE_RST   = 8'd147;
  localparam logic [7:0]  SIGNATURE_TWO_RST   = 8'd11;
  localparam logic [7:0]  FEATURE_FLAGS_RST   = 8'd0;
  localparam logic [15:0] AUTO_EXIT_TICKS_RST = 16'd1200;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_INFO  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_FILL  = 3'd3,
    OP_WRITE = 3'd4,
    OP_ERASE = 3'd5,
    OP_EXIT  = 3'd6
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BOOT_ADDRESS    = 3'd0,
    CFG_WRITE_SLEEP_MS  = 3'd1,
    CFG_SIGNATURE_ONE   = 3'd2,
    CFG_SIGNATURE_TWO   = 3'd3,
    CFG_FEATURE_FLAGS   = 3'd4,
    CFG_AUTO_EXIT_TICKS = 3'd5
  } cfg_reg_t;

  // Which result of an item the datapath works on
  typedef enum logic [1:0] {
    STEP_FIRST  = 2'd0,
    STEP_SECOND = 2'd1,
    STEP_THIRD  = 2'd2
  } step_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
  } stat_t;

  // Bit b is set when low address byte b sits on a page boundary
  function automatic logic [255:0] page_end_map();
    logic [255:0] m;
    m = '0;
    for (int i = 0; i < 256; i++) begin
      m[i] = ((i % PAGE_BYTES) == 0);
    end
    return m;
  endfunction

  localparam logic [255:0] PAGE_END_MAP = page_end_map();

endpackage

>>> design/fbcu_in_if.sv
interface fbcu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  request_code;
  logic [15:0] w_value;
  logic [15:0] w_index;
  logic        app_present;

  modport source (output valid, func, request_code, w_value, w_index, app_present,
                  input ready);
  modport sink (input valid, func, request_code, w_value, w_index, app_present,
                output ready);
endinterface

>>> design/fbcu_out_if.sv
interface fbcu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] flash_address;
  logic [15:0] flash_data;
  logic [63:0] info_reply;
  logic        last;

  modport source (output valid, op, flash_address, flash_data, info_reply, last,
                  input ready);
  modport sink (input valid, op, flash_address, flash_data, info_reply, last,
                output ready);
endinterface

>>> design/fbcu_cfg_if.sv
interface fbcu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/fbcu_ctrl.sv
`include "flash_bootloader_command_unit_assert.svh"

module fbcu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  output logic            result_valid,
  input  logic            result_ready,
  input  fbcu_pkg::stat_t stat,
  output fbcu_pkg::cmd_t  cmd
);
  import fbcu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SECOND,
    S_THIRD
  } state_t;

  state_t state;
  logic   slot_free;

  // Output register is free when empty or being drained this cycle
  assign slot_free  = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  // Drive datapath commands
  always_comb begin
    cmd.load = item_valid && item_ready;
    cmd.exec = (state != S_IDLE) && (!stat.emit || slot_free);
    case (state)
      S_SECOND: cmd.step = STEP_SECOND;
      S_THIRD:  cmd.step = STEP_THIRD;
      default:  cmd.step = STEP_FIRST;
    endcase
  end

  // Sequence the results of one item and hold the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Raise valid on a new beat, drop it once the beat is taken
      if (cmd.exec && stat.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_FIRST;
          end
        end
        S_FIRST, S_SECOND, S_THIRD: begin
          if (cmd.exec) begin
            if (!stat.emit || stat.last) begin
              state <= S_IDLE;
            end else if (state == S_FIRST) begin
              state <= S_SECOND;
            end else begin
              state <= S_THIRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FBCU_ASSERT(a_emit_slot_free, clk, rst, (cmd.exec && stat.emit |-> slot_free), "emit while output register busy")
  `FBCU_ASSERT(a_load_to_first, clk, rst, (cmd.load |=> state == S_FIRST), "accepted beat not processed")
  `FBCU_ASSERT(a_third_after_second, clk, rst, (state == S_THIRD |-> $past(state) == S_SECOND || $past(state) == S_THIRD), "page write step out of order")

endmodule

>>> design/fbcu_datapath.sv
`include "flash_bootloader_command_unit_assert.svh"

module fbcu_datapath (
  input  logic            clk,
  input  logic            rst,
  input  fbcu_pkg::cmd_t  cmd,
  output fbcu_pkg::stat_t stat,
  input  logic            func,
  input  logic [7:0]      request_code,
  input  logic [15:0]     w_value,
  input  logic [15:0]     w_index,
  input  logic            app_present,
  fbcu_cfg_if.sink        cfg,
  output logic [2:0]      op,
  output logic [15:0]     flash_address,
  output logic [15:0]     flash_data,
  output logic [63:0]     info_reply,
  output logic            last
);
  import fbcu_pkg::*;

  // Latched item
  logic        it_func;
  logic [7:0]  it_code;
  logic [15:0] it_wv;
  logic [15:0] it_wi;
  logic        it_app;

  // Configuration
  logic [15:0] boot_address;
  logic [7:0]  write_sleep_ms;
  logic [7:0]  signature_one;
  logic [7:0]  signature_two;
  logic [7:0]  feature_flags;
  logic [15:0] auto_exit_ticks;

  // Unit state
  logic [15:0] cur_addr;
  logic [15:0] idle_count;
  logic        exited;

  logic [15:0] cur_addr_next;
  logic [15:0] idle_count_next;
  logic        exited_next;

  // Candidate result
  op_t         r_op;
  logic [15:0] r_addr;
  logic [15:0] r_data;
  logic [63:0] r_info;

  logic [15:0] cur_plus2;
  logic [15:0] cur_minus2;
  logic [15:0] idle_inc;
  logic [15:0] boot_half;
  logic [15:0] boot_minus4;
  logic        boot_far;
  logic [15:0] fill_src;
  logic [15:0] fill_word;
  logic        write_follows;
  logic [5:0]  mcode;

  assign cfg.ready = 1'b1;

  assign cur_plus2   = cur_addr + 16'd2;
  assign cur_minus2  = cur_addr - 16'd2;
  assign idle_inc    = idle_count + 16'd1;
  assign boot_half   = {1'b0, boot_address[15:1]};
  assign boot_minus4 = boot_address - 16'd4;
  assign boot_far    = (boot_address >= FAR_LIMIT);
  assign mcode       = it_code[5:0] & CODE_MASK[5:0];

  // Patch the reset vector so it jumps into the loader
  assign fill_src = (cmd.step == STEP_SECOND) ? it_wi : it_wv;
  always_comb begin
    fill_word = fill_src;
    if (cur_addr == 16'd0) begin
      fill_word = boot_far ? JMP_FAR_OPCODE : (JMP_NEAR_BASE + boot_half - 16'd1);
    end else if (cur_addr == 16'd2 && boot_far) begin
      fill_word = boot_half;
    end
  end

  // Second fill closes a page below the loader
  assign write_follows = PAGE_END_MAP[cur_plus2[7:0]] && (cur_addr < boot_address);

  // Work out the result and state update of the current step
  always_comb begin
    stat.emit       = 1'b0;
    stat.last       = 1'b1;
    r_op            = OP_NONE;
    r_addr          = '0;
    r_data          = '0;
    r_info          = '0;
    cur_addr_next   = cur_addr;
    idle_count_next = idle_count;
    exited_next     = exited;
    case (cmd.step)
      STEP_FIRST: begin
        if (!exited) begin
          if (it_func) begin
            idle_count_next = idle_inc;
            if (auto_exit_ticks != 16'd0 && idle_inc == auto_exit_ticks && it_app) begin
              stat.emit   = 1'b1;
              r_op        = OP_EXIT;
              exited_next = 1'b1;
            end
          end else begin
            idle_count_next = {8'h00, idle_count[7:0]};
            if (it_code == REQ_INFO) begin
              stat.emit = 1'b1;
              r_op      = OP_INFO;
              r_info    = {8'h00, feature_flags, signature_two, signature_one,
                           write_sleep_ms, PAGE_BYTE_LO, boot_minus4[7:0],
                           boot_minus4[15:8]};
            end else if (it_code == REQ_PAGE) begin
              if (cur_addr != 16'd0) begin
                cur_addr_next = {it_wi[15:8], it_wi[7:0] & PAGE_MASK};
                stat.emit     = 1'b1;
                r_op          = OP_CLEAR;
                r_addr        = cur_addr_next;
              end
            end else if (it_code == REQ_DATA) begin
              stat.emit     = 1'b1;
              stat.last     = 1'b0;
              r_op          = OP_FILL;
              r_addr        = cur_addr;
              r_data        = fill_word;
              cur_addr_next = cur_plus2;
            end else if (mcode == MREQ_ERASE) begin
              stat.emit     = 1'b1;
              r_op          = OP_ERASE;
              cur_addr_next = '0;
            end else if (mcode == MREQ_EXIT) begin
              stat.emit   = 1'b1;
              r_op        = OP_EXIT;
              exited_next = 1'b1;
            end
          end
        end
      end
      STEP_SECOND: begin
        stat.emit     = 1'b1;
        stat.last     = !write_follows;
        r_op          = OP_FILL;
        r_addr        = cur_addr;
        r_data        = fill_word;
        cur_addr_next = cur_plus2;
      end
      STEP_THIRD: begin
        stat.emit = 1'b1;
        r_op      = OP_WRITE;
        r_addr    = cur_minus2;
      end
      default: begin
        stat.emit = 1'b0;
      end
    endcase
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_func <= func;
      it_code <= request_code;
      it_wv   <= w_value;
      it_wi   <= w_index;
      it_app  <= app_present;
    end
  end

  // Take configuration beats
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_address    <= BOOT_ADDRESS_RST;
      write_sleep_ms  <= WRITE_SLEEP_MS_RST;
      signature_one   <= SIGNATURE_ONE_RST;
      signature_two   <= SIGNATURE_TWO_RST;
      feature_flags   <= FEATURE_FLAGS_RST;
      auto_exit_ticks <= AUTO_EXIT_TICKS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        CFG_BOOT_ADDRESS:    boot_address    <= cfg.data;
        CFG_WRITE_SLEEP_MS:  write_sleep_ms  <= cfg.data[7:0];
        CFG_SIGNATURE_ONE:   signature_one   <= cfg.data[7:0];
        CFG_SIGNATURE_TWO:   signature_two   <= cfg.data[7:0];
        CFG_FEATURE_FLAGS:   feature_flags   <= cfg.data[7:0];
        CFG_AUTO_EXIT_TICKS: auto_exit_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // Advance unit state on each executed step
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr   <= '0;
      idle_count <= '0;
      exited     <= 1'b0;
    end else if (cmd.exec) begin
      cur_addr   <= cur_addr_next;
      idle_count <= idle_count_next;
      exited     <= exited_next;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.exec && stat.emit) begin
      op            <= r_op;
      flash_address <= r_addr;
      flash_data    <= r_data;
      info_reply    <= r_info;
      last          <= stat.last;
    end
  end

  `FBCU_ASSERT(a_exited_sticks, clk, rst, (exited |=> exited), "exit flag dropped")
  `FBCU_ASSERT(a_addr_even, clk, rst, (!cur_addr[0]), "page address became odd")
  `FBCU_ASSERT(a_third_emits, clk, rst, (cmd.exec && cmd.step == STEP_THIRD |-> stat.emit && stat.last), "page write step without result")

endmodule

>>> design/flash_bootloader_command_unit.sv
// Channel  Dir  Beat content
// item     in   func, request_code, w_value, w_index, app_present
// result   out  op, flash_address, flash_data, info_reply, last
// cfg      in   index, data (register write)
//
// An item is taken in the idle state and each result in a step of its own:
// a tick or a request with at most one result uses the first step; a data
// request adds the second, the third on a page write; fbcu_ctrl sets this.
// rst is synchronous and restores the register reset values and clears state.
// A stalled result holds the output register; the next item is still taken
// while one result waits, and cfg writes are taken every cycle.
module flash_bootloader_command_unit (
  input  logic     clk,
  input  logic     rst,
  fbcu_in_if.sink  item,
  fbcu_out_if.source result,
  fbcu_cfg_if.sink cfg
);
  import fbcu_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic        result_valid;
  logic [2:0]  op;
  logic [15:0] flash_address;
  logic [15:0] flash_data;
  logic [63:0] info_reply;
  logic        last;

  fbcu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result_valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  fbcu_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (item.func),
    .request_code  (item.request_code),
    .w_value       (item.w_value),
    .w_index       (item.w_index),
    .app_present   (item.app_present),
    .cfg           (cfg),
    .op            (op),
    .flash_address (flash_address),
    .flash_data    (flash_data),
    .info_reply    (info_reply),
    .last          (last)
  );

  assign result.valid         = result_valid;
  assign result.op            = op;
  assign result.flash_address = flash_address;
  assign result.flash_data    = flash_data;
  assign result.info_reply    = info_reply;
  assign result.last          = last;

endmodule

>>> tb/sv/fbcu_check_pkg.sv
package fbcu_check_pkg;
  import fbcu_pkg::*;

  // Item kinds on the input channel
  localparam logic FUNC_SETUP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  request_code;
    logic [15:0] w_value;
    logic [15:0] w_index;
    logic        app_present;
  } cmd_item_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] flash_address;
    logic [15:0] flash_data;
    logic [63:0] info_reply;
    logic        last;
  } flash_op_t;

  // Tracks loader state and holds the flash operations still owed by the block
  class flash_op_tracker;
    logic [15:0] boot_addr;
    logic [7:0]  sleep_ms;
    logic [7:0]  sig_one;
    logic [7:0]  sig_two;
    logic [7:0]  flags;
    logic [15:0] exit_ticks;

    logic [15:0] cur_addr;
    logic [15:0] idle_cnt;
    bit          has_exited;

    flash_op_t   pending_ops[$];
    flash_op_t   held;
    bit          held_valid;

    int          errors;
    int          checked;
    int          op_seen[8];

    function new();
      boot_addr  = BOOT_ADDRESS_RST;
      sleep_ms   = WRITE_SLEEP_MS_RST;
      sig_one    = SIGNATURE_ONE_RST;
      sig_two    = SIGNATURE_TWO_RST;
      flags      = FEATURE_FLAGS_RST;
      exit_ticks = AUTO_EXIT_TICKS_RST;
      cur_addr   = 16'd0;
      idle_cnt   = 16'd0;
      has_exited = 1'b0;
      held_valid = 1'b0;
      errors     = 0;
      checked    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        CFG_BOOT_ADDRESS:    boot_addr  = val;
        CFG_WRITE_SLEEP_MS:  sleep_ms   = val[7:0];
        CFG_SIGNATURE_ONE:   sig_one    = val[7:0];
        CFG_SIGNATURE_TWO:   sig_two    = val[7:0];
        CFG_FEATURE_FLAGS:   flags      = val[7:0];
        CFG_AUTO_EXIT_TICKS: exit_ticks = val;
        default: ;
      endcase
    endfunction

    // Hold back the newest op so the final one of an item can carry last
    function void emit(op_t kind, logic [15:0] addr, logic [15:0] data, logic [63:0] info);
      if (held_valid) pending_ops.push_back(held);
      held = '{op: kind, flash_address: addr, flash_data: data, info_reply: info, last: 1'b0};
      held_valid = 1'b1;
    endfunction

    function logic [63:0] info_bytes();
      logic [15:0] size;
      size = boot_addr - 16'd4;
      return {8'h00, flags, sig_two, sig_one, sleep_ms, 8'(PAGE_BYTES % 256),
              size[7:0], size[15:8]};
    endfunction

    // Patch the reset vector so it jumps into the loader, then advance
    function void fill(logic [15:0] word);
      logic [15:0] data;
      data = word;
      if (boot_addr < FAR_LIMIT) begin
        if (cur_addr == 16'd0) data = JMP_NEAR_BASE + (boot_addr >> 1) - 16'd1;
      end else if (cur_addr == 16'd0) begin
        data = JMP_FAR_OPCODE;
      end else if (cur_addr == 16'd2) begin
        data = boot_addr >> 1;
      end
      emit(OP_FILL, cur_addr, data, 64'd0);
      cur_addr = cur_addr + 16'd2;
    endfunction

    function void take_item(cmd_item_t it);
      logic [15:0] wa;
      logic [7:0]  masked;
      logic [7:0]  page_mask;
      page_mask = 8'(~(PAGE_BYTES - 1));
      if (!has_exited) begin
        if (it.func == FUNC_TICK) begin
          idle_cnt = idle_cnt + 16'd1;
          if (exit_ticks != 16'd0 && idle_cnt == exit_ticks && it.app_present) begin
            emit(OP_EXIT, 16'd0, 16'd0, 64'd0);
            has_exited = 1'b1;
          end
        end else begin
          idle_cnt[15:8] = 8'h00;
          masked = it.request_code & CODE_MASK;
          if (it.request_code == REQ_INFO) begin
            emit(OP_INFO, 16'd0, 16'd0, info_bytes());
          end else if (it.request_code == REQ_PAGE) begin
            if (cur_addr != 16'd0) begin
              cur_addr = {it.w_index[15:8], it.w_index[7:0] & page_mask};
              emit(OP_CLEAR, cur_addr, 16'd0, 64'd0);
            end
          end else if (it.request_code == REQ_DATA) begin
            fill(it.w_value);
            fill(it.w_index);
            // write the page once its last word is in, unless it sits in the loader
            if ((int'(cur_addr[7:0]) % PAGE_BYTES) == 0) begin
              wa = cur_addr - 16'd2;
              if (wa < boot_addr) emit(OP_WRITE, wa, 16'd0, 64'd0);
            end
          end else if (masked[5:0] == MREQ_ERASE) begin
            cur_addr = 16'd0;
            emit(OP_ERASE, 16'd0, 16'd0, 64'd0);
          end else if (masked[5:0] == MREQ_EXIT) begin
            emit(OP_EXIT, 16'd0, 16'd0, 64'd0);
            has_exited = 1'b1;
          end
        end
      end
      if (held_valid) begin
        held.last = 1'b1;
        pending_ops.push_back(held);
        held_valid = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_op(flash_op_t got);
      flash_op_t want;
      if (pending_ops.size() == 0) begin
        report($sformatf("result op %0d addr %h with nothing expected",
                         got.op, got.flash_address));
      end else begin
        want = pending_ops.pop_front();
        checked++;
        op_seen[want.op]++;
        if (got.op !== want.op)
          report($sformatf("op %0d, expected %0d", got.op, want.op));
        if (got.flash_address !== want.flash_address)
          report($sformatf("op %0d flash_address %h, expected %h",
                           want.op, got.flash_address, want.flash_address));
        if (got.flash_data !== want.flash_data)
          report($sformatf("op %0d flash_data %h, expected %h",
                           want.op, got.flash_data, want.flash_data));
        if (got.info_reply !== want.info_reply)
          report($sformatf("op %0d info_reply %h, expected %h",
                           want.op, got.info_reply, want.info_reply));
        if (got.last !== want.last)
          report($sformatf("op %0d last %b, expected %b", want.op, got.last, want.last));
      end
    endtask
  endclass

endpackage

>>> tb/sv/flash_bootloader_command_unit_test.sv
module flash_bootloader_command_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbcu_pkg::*;
  import fbcu_check_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 30;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fbcu_in_if  item_ch ();
  fbcu_out_if result_ch ();
  fbcu_cfg_if cfg_ch ();

  flash_bootloader_command_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  flash_op_tracker tracker;
  bit stall_request = 1'b0;
  int burst_left = 0;
  int items_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("flash_bootloader_command_unit_test NOT OK");
      $finish;
    end
  end

  // Check every result beat against the oldest expected op
  always @(posedge clk) begin
    flash_op_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.op            = op_t'(result_ch.op);
      got.flash_address = result_ch.flash_address;
      got.flash_data    = result_ch.flash_data;
      got.info_reply    = result_ch.info_reply;
      got.last          = result_ch.last;
      tracker.check_op(got);
    end
  end

  // Drive result ready on a pattern that is picked anew at random
  initial begin : result_sink
    sink_mode_t mode;
    int left;
    int phase;
    result_ch.ready = 1'b0;
    mode = SINK_OPEN;
    left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        // hold off long enough for the block to back up into its input
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          left = $urandom_range(10, 60);
        end
        left--;
        phase++;
        case (mode)
          SINK_OPEN:   result_ch.ready = 1'b1;
          SINK_COIN:   result_ch.ready = 1'($urandom_range(0, 1));
          SINK_SPARSE: result_ch.ready = ($urandom_range(0, 3) == 0);
          default:     result_ch.ready = ((phase % 5) < 3);
        endcase
      end
    end
  end

  function automatic cmd_item_t setup_item(logic [7:0] code, logic [15:0] wv, logic [15:0] wi);
    cmd_item_t it;
    it.func         = FUNC_SETUP;
    it.request_code = code;
    it.w_value      = wv;
    it.w_index      = wi;
    it.app_present  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic cmd_item_t tick_item(logic app);
    cmd_item_t it;
    it.func         = FUNC_TICK;
    it.request_code = 8'($urandom);
    it.w_value      = 16'($urandom);
    it.w_index      = 16'($urandom);
    it.app_present  = app;
    return it;
  endfunction

  // Steer random items away from an exit, which would end all results until reset
  function automatic cmd_item_t make_safe(cmd_item_t it);
    cmd_item_t fixed;
    fixed = it;
    if (fixed.func == FUNC_SETUP && fixed.request_code[5:0] == MREQ_EXIT)
      fixed.request_code[0] = 1'b1;
    if (fixed.func == FUNC_TICK && tracker.exit_ticks != 16'd0 &&
        tracker.idle_cnt + 16'd1 == tracker.exit_ticks)
      fixed.app_present = 1'b0;
    return fixed;
  endfunction

  // Offer one beat in bursts separated by random gaps
  task automatic send_item(input cmd_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        @(negedge clk);
        item_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_ch.valid        = 1'b1;
    item_ch.func         = it.func;
    item_ch.request_code = it.request_code;
    item_ch.w_value      = it.w_value;
    item_ch.w_index      = it.w_index;
    item_ch.app_present  = it.app_present;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    tracker.take_item(it);
    items_sent++;
  endtask

  // Drop valid and wait for every owed result, then let the block settle
  task automatic drain();
    @(negedge clk);
    item_ch.valid = 1'b0;
    burst_left = 0;
    while (tracker.pending_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_register(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(input logic [15:0] boot, input logic [7:0] sleep,
                           input logic [7:0] sig1, input logic [7:0] sig2,
                           input logic [7:0] flg, input logic [15:0] ticks);
    write_reg(CFG_BOOT_ADDRESS, boot);
    write_reg(CFG_WRITE_SLEEP_MS, {8'h00, sleep});
    write_reg(CFG_SIGNATURE_ONE, {8'h00, sig1});
    write_reg(CFG_SIGNATURE_TWO, {8'h00, sig2});
    write_reg(CFG_FEATURE_FLAGS, {8'h00, flg});
    write_reg(CFG_AUTO_EXIT_TICKS, ticks);
    settings_used++;
  endtask

  task automatic random_setup();
    logic [15:0] boot;
    logic [15:0] ticks;
    case ($urandom_range(0, 6))
      0:       boot = 16'd256;
      1:       boot = 16'hFFFF;
      2:       boot = FAR_LIMIT;
      3:       boot = FAR_LIMIT - 16'd2;
      4:       boot = BOOT_ADDRESS_RST;
      5:       boot = 16'($urandom_range(4, 1023) * 64);
      default: boot = 16'($urandom_range(256, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       ticks = 16'd0;
      1:       ticks = 16'($urandom_range(1, 12));
      2:       ticks = 16'hFFFF;
      default: ticks = 16'($urandom_range(13, 300));
    endcase
    configure(boot, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), ticks);
  endtask

  task automatic send_random_data();
    send_item(make_safe(setup_item(REQ_DATA, 16'($urandom), 16'($urandom))));
  endtask

  // One random sequence; most of them program a page
  task automatic run_sequence();
    int kind;
    int count;
    logic [15:0] page;
    logic [7:0]  code;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // leave address 0 first so the page request takes effect
      if (tracker.cur_addr == 16'd0) send_random_data();
      case ($urandom_range(0, 9))
        0:       page = {8'hFF, 8'($urandom_range(8'hC0, 8'hFF))};
        1, 2:    page = 16'($urandom);
        default: page = 16'($urandom_range(0, int'(tracker.boot_addr) - 1));
      endcase
      send_item(make_safe(setup_item(REQ_PAGE, 16'($urandom), page)));
      count = ($urandom_range(0, 9) < 6) ? PAGE_BYTES / 4 : $urandom_range(1, PAGE_BYTES / 4 + 4);
      repeat (count) begin
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1) == 0)
            send_item(make_safe(tick_item(1'($urandom_range(0, 1)))));
          else
            send_item(make_safe(setup_item(REQ_INFO, 16'($urandom), 16'($urandom))));
        end
        send_random_data();
      end
    end else if (kind == 6) begin
      // noise: any kind, any code
      repeat ($urandom_range(1, 4)) begin
        code = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
          send_item(make_safe(tick_item(1'($urandom_range(0, 1)))));
        else
          send_item(make_safe(setup_item(code, 16'($urandom), 16'($urandom))));
      end
    end else if (kind == 7) begin
      code = {2'($urandom_range(0, 3)), MREQ_ERASE};
      send_item(make_safe(setup_item(code, 16'($urandom), 16'($urandom))));
      send_item(make_safe(tick_item(1'($urandom_range(0, 1)))));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 6)) send_item(make_safe(tick_item(1'($urandom_range(0, 1)))));
    end else begin
      send_item(make_safe(setup_item(REQ_INFO, 16'($urandom), 16'($urandom))));
      send_item(make_safe(tick_item(1'($urandom_range(0, 1)))));
    end
  endtask

  initial begin : stimulus
    int start;
    item_ch.valid        = 1'b0;
    item_ch.func         = FUNC_SETUP;
    item_ch.request_code = REQ_INFO;
    item_ch.w_value      = 16'd0;
    item_ch.w_index      = 16'd0;
    item_ch.app_present  = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_BOOT_ADDRESS;
    cfg_ch.data          = 16'd0;
    rst                  = 1'b1;
    tracker = new();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Reset settings: page request at address 0 is ignored, near patch, masked codes
    send_item(tick_item(1'b1));
    send_item(setup_item(REQ_INFO, 16'h0000, 16'h0000));
    send_item(setup_item(REQ_PAGE, 16'hFFFF, 16'h1234));
    send_item(setup_item(REQ_DATA, 16'hFFFF, 16'h0000));
    send_item(setup_item(REQ_PAGE, 16'h0000, 16'hFFFF));
    send_item(setup_item(REQ_DATA, 16'hAAAA, 16'h5555));
    send_item(setup_item(REQ_PAGE, 16'h0000, 16'h003F));
    send_item(setup_item(REQ_DATA, 16'h1111, 16'h2222));
    send_item(setup_item({2'b00, MREQ_ERASE}, 16'h0000, 16'h0000));
    send_item(setup_item({2'b01, 6'(REQ_INFO)}, 16'hFFFF, 16'hFFFF));
    send_item(setup_item(8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(setup_item({2'b01, 6'(REQ_PAGE)}, 16'h0000, 16'h0040));
    send_item(setup_item({2'b01, 6'(REQ_DATA)}, 16'h1234, 16'h5678));
    send_item(setup_item({2'b11, MREQ_ERASE}, 16'h0000, 16'h0000));
    send_item(tick_item(1'b0));

    // Top loader address, unaligned: far patch, exit disabled
    drain();
    configure(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'hA5, 16'd0);
    send_item(setup_item(REQ_INFO, 16'h0000, 16'h0000));
    send_item(setup_item(REQ_DATA, 16'h0123, 16'h4567));
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b1));

    // Lowest loader address
    drain();
    configure(16'd256, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(setup_item(REQ_INFO, 16'h0000, 16'h0000));
    send_item(setup_item({2'b10, MREQ_ERASE}, 16'h0000, 16'h0000));
    send_item(setup_item(REQ_DATA, 16'h0000, 16'hFFFF));

    // Random phases, each under new settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      random_setup();
      if (p == 1) stall_request = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) run_sequence();
    end

    // Exit on the idle count, then confirm everything after it is ignored
    drain();
    send_item(setup_item(REQ_INFO, 16'h0000, 16'h0000));
    drain();
    write_reg(CFG_AUTO_EXIT_TICKS, tracker.idle_cnt + 16'd2);
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b1));
    send_item(setup_item(REQ_INFO, 16'h0000, 16'h0000));
    send_item(setup_item({2'b10, MREQ_EXIT}, 16'h0000, 16'h0000));
    send_item(setup_item(REQ_DATA, 16'hBEEF, 16'hCAFE));
    send_item(tick_item(1'b1));
    drain();

    $display("covered %0d items under %0d register settings: %0d fills, %0d page writes,",
             items_sent, settings_used, tracker.op_seen[OP_FILL], tracker.op_seen[OP_WRITE]);
    $display("  %0d info replies, %0d clears, %0d erases, %0d exits; %0d results, %0d mismatches",
             tracker.op_seen[OP_INFO], tracker.op_seen[OP_CLEAR], tracker.op_seen[OP_ERASE],
             tracker.op_seen[OP_EXIT], tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("flash_bootloader_command_unit_test OK");
    end else begin
      $display("flash_bootloader_command_unit_test NOT OK");
    end
    $finish;
  end

endmodule
